@@ sv/polar_lattice_pose_sampler_top_macros.svh @@
// Assertion macros shared by the checker of the pose sampler.
// Depends on nothing; include by bare file name.
`ifndef POLAR_LATTICE_POSE_SAMPLER_TOP_MACROS_SVH
`define POLAR_LATTICE_POSE_SAMPLER_TOP_MACROS_SVH
// Plain property under clock and active-low reset.
`define PLSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Hold a signal stable in the cycle after a condition.
`define PLSP_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

@@ sv/plsp_pkg.sv @@
// Package of the polar lattice pose sampler: widths, constants, register codes.
// Depends on nothing.
package plsp_pkg;

  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int DEN_W   = 7;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 18;
  localparam int NUM_W   = 24;
  localparam int XY_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ATAN_N  = 24;

  localparam int DEF_MAX_SAMPLES  = 64;
  localparam int DEF_MAX_HEADINGS = 64;
  localparam int DEF_CORDIC_STEPS = 16;

  localparam int PI_Q28      = 843314857;
  localparam int HALF_PI_Q28 = 421657428;
  localparam int TWO_PI_Q28  = 1686629713;
  localparam int GAIN_Q30    = 652032874;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADINGS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HMIN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HMAX     = 3'd6;

  localparam logic [CNT_W-1:0] RST_SAMPLES  = 7'd5;
  localparam logic [CNT_W-1:0] RST_HEADINGS = 7'd3;
  localparam logic [VAL_W-1:0] RST_DISTANCE = 16'd5120;
  localparam logic signed [VAL_W-1:0] RST_AMIN = -16'sd1787;
  localparam logic signed [VAL_W-1:0] RST_AMAX = 16'sd1787;
  localparam logic signed [VAL_W-1:0] RST_HMIN = -16'sd1787;
  localparam logic signed [VAL_W-1:0] RST_HMAX = 16'sd1787;

  localparam logic signed [XY_W-1:0] ATAN_Q28 [0:ATAN_N-1] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
    32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
    32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
    32'sd256, 32'sd128, 32'sd64, 32'sd32
  };

endpackage

@@ sv/plsp_if.sv @@
// Channel interfaces of the pose sampler: index input, pose output, register writes.
// Depends on plsp_pkg.
interface plsp_in_if;
  logic                            valid;
  logic                            ready;
  logic [plsp_pkg::IDX_W-1:0]      angle_index;
  logic [plsp_pkg::IDX_W-1:0]      heading_index;
  modport source (output valid, angle_index, heading_index, input ready);
  modport sink (input valid, angle_index, heading_index, output ready);
endinterface

interface plsp_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [plsp_pkg::OUT_W-1:0] pos_x;
  logic signed [plsp_pkg::OUT_W-1:0] pos_y;
  logic signed [plsp_pkg::OUT_W-1:0] yaw;
  modport source (output valid, pos_x, pos_y, yaw, input ready);
  modport sink (input valid, pos_x, pos_y, yaw, output ready);
endinterface

interface plsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [plsp_pkg::CFG_IDX_W-1:0]    index;
  logic [plsp_pkg::VAL_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/polar_lattice_pose_sampler_top.sv @@
// Top level of the polar lattice pose sampler: register file, prep, divider, CORDIC, output.
// Depends on plsp_pkg, plsp_if, plsp_div and plsp_cordic.
//
//  channel   modport  handshake       word
//  in_ch     sink     valid/ready     angle_index, heading_index
//  out_ch    source   valid/ready     pos_x, pos_y, yaw
//  cfg_ch    sink     valid/ready     index, data (ready tied high)
//
// One word enters per cycle unless the output word waits unread; the pipe runs through
// stage 0, bit-per-stage divider, stage 1, stage-per-rotation CORDIC, stages 2 and 3.
// Every stage advances together on one enable: when the output word waits unread
// the whole pipe holds, so nothing is lost or repeated.
// Reset (synchronous, active low) clears every valid bit and loads register defaults.
// The user must write registers only while the pipe is empty; the block does not enforce it.
module polar_lattice_pose_sampler_top #(
  parameter int MAX_SAMPLES  = plsp_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_HEADINGS = plsp_pkg::DEF_MAX_HEADINGS,
  parameter int CORDIC_STEPS = plsp_pkg::DEF_CORDIC_STEPS
) (
  input logic         clk,
  input logic         rst_n,
  plsp_in_if.sink     in_ch,
  plsp_out_if.source  out_ch,
  plsp_cfg_if.sink    cfg_ch
);

  localparam int CW  = plsp_pkg::CNT_W;
  localparam int DW  = plsp_pkg::DEN_W;
  localparam int VW  = plsp_pkg::VAL_W;
  localparam int NW  = plsp_pkg::NUM_W;
  localparam int XW  = plsp_pkg::XY_W;
  localparam int OW  = plsp_pkg::OUT_W;
  localparam int PW  = VW + 1 + XW;      // distance times cos/sin
  localparam int DSB = 2 + 2 * VW;       // divider sideband
  localparam int CSB = 2 * VW + 1;       // CORDIC sideband: 17-bit heading, 16-bit angle
  localparam int RW  = PW + 1 - 30;      // rounded product width

  // ------------------------------------------------------------------
  // Register file: written straight from the write channel
  // ------------------------------------------------------------------
  logic [CW-1:0]        samples_r, headings_r;
  logic [VW-1:0]        dist_r;
  logic signed [VW-1:0] amin_r, amax_r, hmin_r, hmax_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r  <= plsp_pkg::RST_SAMPLES;
      headings_r <= plsp_pkg::RST_HEADINGS;
      dist_r     <= plsp_pkg::RST_DISTANCE;
      amin_r     <= plsp_pkg::RST_AMIN;
      amax_r     <= plsp_pkg::RST_AMAX;
      hmin_r     <= plsp_pkg::RST_HMIN;
      hmax_r     <= plsp_pkg::RST_HMAX;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        plsp_pkg::REG_SAMPLES:  samples_r  <= cfg_ch.data[CW-1:0];
        plsp_pkg::REG_HEADINGS: headings_r <= cfg_ch.data[CW-1:0];
        plsp_pkg::REG_DISTANCE: dist_r     <= cfg_ch.data;
        plsp_pkg::REG_AMIN:     amin_r     <= cfg_ch.data;
        plsp_pkg::REG_AMAX:     amax_r     <= cfg_ch.data;
        plsp_pkg::REG_HMIN:     hmin_r     <= cfg_ch.data;
        plsp_pkg::REG_HMAX:     hmax_r     <= cfg_ch.data;
        default: ;  // unknown register: drop the write
      endcase
    end
  end

  // Global advance: the pipe moves whenever the output slot is free or being read
  logic out_vld_r;
  logic adv;
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ------------------------------------------------------------------
  // Stage 0: clamp counts and indices, form rounded-divide numerators.
  // Each lane computes round(diff * idx / den) as (|num| + den/2) / den.
  // Single sample: idx 0, den 1, base angle_min.
  // Single heading: idx 1, den 2, base 0, giving half the span.
  // ------------------------------------------------------------------
  logic [CW-1:0]         eff_s, eff_h, den_s, den_h, mul_s, mul_h, ai_w, hi_w;
  logic                  one_s, one_h;
  logic signed [VW:0]    diff_a, diff_h;
  logic signed [VW+CW:0] prod_a, prod_h;
  logic [VW+CW:0]        mag_a, mag_h;
  logic signed [VW-1:0]  base_h;

  always_comb begin
    eff_s = ({25'd0, samples_r} > 32'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : samples_r;
    eff_h = ({25'd0, headings_r} > 32'(MAX_HEADINGS)) ? CW'(MAX_HEADINGS) : headings_r;
    one_s = (eff_s <= CW'(1));
    one_h = (eff_h <= CW'(1));
    ai_w  = CW'(in_ch.angle_index);
    hi_w  = CW'(in_ch.heading_index);

    if (one_s) begin
      den_s = CW'(1);
      mul_s = '0;
    end else begin
      den_s = eff_s - CW'(1);
      mul_s = (ai_w > den_s) ? den_s : ai_w;
    end

    if (one_h) begin
      den_h  = CW'(2);
      mul_h  = CW'(1);
      base_h = '0;
    end else begin
      den_h  = eff_h - CW'(1);
      mul_h  = (hi_w > den_h) ? den_h : hi_w;
      base_h = hmin_r;
    end

    diff_a = {amax_r[VW-1], amax_r} - {amin_r[VW-1], amin_r};
    diff_h = {hmax_r[VW-1], hmax_r} - {hmin_r[VW-1], hmin_r};
    prod_a = diff_a * $signed({1'b0, mul_s});
    prod_h = diff_h * $signed({1'b0, mul_h});
    mag_a  = prod_a[VW+CW] ? (VW+CW+1)'(-prod_a) : prod_a;
    mag_h  = prod_h[VW+CW] ? (VW+CW+1)'(-prod_h) : prod_h;
  end

  logic                 s0_vld_r;
  logic [NW-1:0]        s0_num_r [2];
  logic [DW-1:0]        s0_den_r [2];
  logic [1:0]           s0_neg_r;
  logic signed [VW-1:0] s0_base_a_r, s0_base_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r[0] <= NW'(mag_a) + NW'(den_s >> 1);
      s0_num_r[1] <= NW'(mag_h) + NW'(den_h >> 1);
      s0_den_r[0] <= DW'(den_s);
      s0_den_r[1] <= DW'(den_h);
      s0_neg_r    <= {prod_h[VW+CW], prod_a[VW+CW]};
      s0_base_a_r <= amin_r;
      s0_base_h_r <= base_h;
    end
  end

  // ------------------------------------------------------------------
  // Divider: angle lane 0, heading lane 1
  // ------------------------------------------------------------------
  logic           dv_vld;
  logic [NW-1:0]  dv_quo [2];
  logic [DSB-1:0] dv_sb;

  plsp_div #(
    .NW    (NW),
    .DW    (DW),
    .SBW   (DSB),
    .LANES (2)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s0_vld_r),
    .num_i   (s0_num_r),
    .den_i   (s0_den_r),
    .sb_i    ({s0_neg_r, s0_base_h_r, s0_base_a_r}),
    .out_vld (dv_vld),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  // ------------------------------------------------------------------
  // Stage 1: restore sign and add the base. The angle fits 16 bits; the
  // heading needs 17, as half of the widest span is +32768.
  // ------------------------------------------------------------------
  logic signed [NW+1:0] qa_s, qh_s, a_sum, h_sum;
  logic                 s1_vld_r;
  logic signed [VW-1:0] s1_a_r;
  logic signed [VW:0]   s1_h_r;

  always_comb begin
    qa_s  = $signed({2'b00, dv_quo[0]});
    qh_s  = $signed({2'b00, dv_quo[1]});
    a_sum = (NW+2)'($signed(dv_sb[VW-1:0]))
          + (dv_sb[DSB-2] ? -qa_s : qa_s);
    h_sum = (NW+2)'($signed(dv_sb[2*VW-1:VW]))
          + (dv_sb[DSB-1] ? -qh_s : qh_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r <= VW'(a_sum);
      s1_h_r <= (VW+1)'(h_sum);
    end
  end

  // ------------------------------------------------------------------
  // CORDIC: cos and sin of the position angle, heading rides alongside
  // ------------------------------------------------------------------
  logic                 cd_vld, cd_neg;
  logic signed [XW-1:0] cd_cos, cd_sin;
  logic [CSB-1:0]       cd_sb;

  plsp_cordic #(
    .STEPS (CORDIC_STEPS),
    .SBW   (CSB)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s1_vld_r),
    .ang_i   (s1_a_r),
    .sb_i    ({s1_h_r, s1_a_r}),
    .out_vld (cd_vld),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin),
    .neg_o   (cd_neg),
    .sb_o    (cd_sb)
  );

  // ------------------------------------------------------------------
  // Stage 2: scale by the radius, sum the yaw
  // ------------------------------------------------------------------
  logic                 s2_vld_r, s2_neg_r;
  logic signed [PW-1:0] s2_px_r, s2_py_r;
  logic signed [VW:0]   s2_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_px_r  <= $signed({1'b0, dist_r}) * cd_cos;
      s2_py_r  <= $signed({1'b0, dist_r}) * cd_sin;
      s2_neg_r <= cd_neg;
      s2_yaw_r <= $signed(cd_sb[CSB-1:VW])
                + $signed({cd_sb[VW-1], cd_sb[VW-1:0]});
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: apply the half-turn sign, round Q.38 to Q.8, saturate
  // ------------------------------------------------------------------
  function automatic logic signed [OW-1:0] sat_out(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi, lo;
    hi = RW'(131071);
    lo = -RW'(131072);
    if (v > hi) begin
      sat_out = OW'(hi);
    end else if (v < lo) begin
      sat_out = OW'(lo);
    end else begin
      sat_out = OW'(v);
    end
  endfunction

  logic signed [PW:0]   px_n, py_n;
  logic signed [RW-1:0] px_rnd, py_rnd, yaw_w;

  always_comb begin
    px_n   = s2_neg_r ? -(PW+1)'(s2_px_r) : (PW+1)'(s2_px_r);
    py_n   = s2_neg_r ? -(PW+1)'(s2_py_r) : (PW+1)'(s2_py_r);
    px_rnd = RW'((px_n + (PW+1)'(1 << 29)) >>> 30);
    py_rnd = RW'((py_n + (PW+1)'(1 << 29)) >>> 30);
    yaw_w  = RW'(s2_yaw_r);
  end

  logic signed [OW-1:0] out_x_r, out_y_r, out_yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r   <= sat_out(px_rnd);
      out_y_r   <= sat_out(py_rnd);
      out_yaw_r <= sat_out(yaw_w);
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.pos_x = out_x_r;
  assign out_ch.pos_y = out_y_r;
  assign out_ch.yaw   = out_yaw_r;

endmodule

@@ sv/plsp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
// Depends on nothing; sideband word travels alongside.
module plsp_div #(
  parameter int NW    = 24,
  parameter int DW    = 7,
  parameter int SBW   = 8,
  parameter int LANES = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [NW-1:0]  num_i [LANES],
  input  logic [DW-1:0]  den_i [LANES],
  input  logic [SBW-1:0] sb_i,
  output logic           out_vld,
  output logic [NW-1:0]  quo_o [LANES],
  output logic [SBW-1:0] sb_o
);

  logic [DW-1:0]  rem_r [NW][LANES];
  logic [NW-1:0]  nq_r  [NW][LANES];
  logic [DW-1:0]  den_r [NW][LANES];
  logic           vld_r [NW];
  logic [SBW-1:0] sb_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0]  rem_p [LANES];
    logic [NW-1:0]  nq_p  [LANES];
    logic [DW-1:0]  den_p [LANES];
    logic [DW-1:0]  rem_nxt [LANES];
    logic [NW-1:0]  nq_nxt  [LANES];
    logic           vld_p;
    logic [SBW-1:0] sb_p;

    if (k == 0) begin : g_first
      assign vld_p = in_vld;
      assign sb_p  = sb_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_p[l] = '0;
        assign nq_p[l]  = num_i[l];
        assign den_p[l] = den_i[l];
      end
    end else begin : g_next
      assign vld_p = vld_r[k-1];
      assign sb_p  = sb_r[k-1];
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_p[l] = rem_r[k-1][l];
        assign nq_p[l]  = nq_r[k-1][l];
        assign den_p[l] = den_r[k-1][l];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      always_comb begin
        trial      = {rem_p[l], nq_p[l][NW-1]};
        ge         = (trial >= {1'b0, den_p[l]});
        rem_nxt[l] = ge ? DW'(trial - {1'b0, den_p[l]}) : DW'(trial);
        nq_nxt[l]  = {nq_p[l][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_p;
        for (int l = 0; l < LANES; l++) begin
          rem_r[k][l] <= rem_nxt[l];
          nq_r[k][l]  <= nq_nxt[l];
          den_r[k][l] <= den_p[l];
        end
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign sb_o    = sb_r[NW-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = nq_r[NW-1][l];
  end

endmodule

@@ sv/plsp_cordic.sv @@
// Pipelined rotation CORDIC: one fold stage, then one micro-rotation per stage.
// Depends on plsp_pkg for the gain, pi constants and atan table.
module plsp_cordic #(
  parameter int STEPS = 16,
  parameter int SBW   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [plsp_pkg::VAL_W-1:0] ang_i,
  input  logic [SBW-1:0]                    sb_i,
  output logic                              out_vld,
  output logic signed [plsp_pkg::XY_W-1:0]  cos_o,
  output logic signed [plsp_pkg::XY_W-1:0]  sin_o,
  output logic                              neg_o,
  output logic [SBW-1:0]                    sb_o
);

  localparam int XW = plsp_pkg::XY_W;
  localparam logic signed [XW:0] PI_Z      = (XW+1)'(plsp_pkg::PI_Q28);
  localparam logic signed [XW:0] HALF_PI_Z = (XW+1)'(plsp_pkg::HALF_PI_Q28);
  localparam logic signed [XW:0] TWO_PI_Z  = (XW+1)'(plsp_pkg::TWO_PI_Q28);
  localparam logic signed [XW-1:0] GAIN    = XW'(plsp_pkg::GAIN_Q30);

  // fold into [-pi/2, pi/2], flag a half turn
  logic signed [XW:0]   z0, z1, z2;
  logic                 neg_f;
  logic signed [XW-1:0] zf_r;
  logic                 negf_r, vldf_r;
  logic [SBW-1:0]       sbf_r;

  always_comb begin
    z0    = {ang_i[plsp_pkg::VAL_W-1], ang_i, 16'd0};
    z1    = z0;
    if (z0 > PI_Z) begin
      z1 = z0 - TWO_PI_Z;
    end else if (z0 < -PI_Z) begin
      z1 = z0 + TWO_PI_Z;
    end
    z2    = z1;
    neg_f = 1'b0;
    if (z1 > HALF_PI_Z) begin
      z2    = z1 - PI_Z;
      neg_f = 1'b1;
    end else if (z1 < -HALF_PI_Z) begin
      z2    = z1 + PI_Z;
      neg_f = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldf_r <= 1'b0;
    end else if (en) begin
      vldf_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r   <= XW'(z2);
      negf_r <= neg_f;
      sbf_r  <= sb_i;
    end
  end

  logic signed [XW-1:0] x_r [STEPS];
  logic signed [XW-1:0] y_r [STEPS];
  logic signed [XW-1:0] z_r [STEPS];
  logic                 neg_r [STEPS];
  logic                 vld_r [STEPS];
  logic [SBW-1:0]       sb_r  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_p, y_p, z_p, x_nxt, y_nxt, z_nxt;
    logic                 neg_p, vld_p;
    logic [SBW-1:0]       sb_p;

    if (i == 0) begin : g_first
      assign x_p   = GAIN;
      assign y_p   = '0;
      assign z_p   = zf_r;
      assign neg_p = negf_r;
      assign vld_p = vldf_r;
      assign sb_p  = sbf_r;
    end else begin : g_next
      assign x_p   = x_r[i-1];
      assign y_p   = y_r[i-1];
      assign z_p   = z_r[i-1];
      assign neg_p = neg_r[i-1];
      assign vld_p = vld_r[i-1];
      assign sb_p  = sb_r[i-1];
    end

    always_comb begin
      if (!z_p[XW-1]) begin
        x_nxt = x_p - (y_p >>> i);
        y_nxt = y_p + (x_p >>> i);
        z_nxt = z_p - plsp_pkg::ATAN_Q28[i];
      end else begin
        x_nxt = x_p + (y_p >>> i);
        y_nxt = y_p - (x_p >>> i);
        z_nxt = z_p + plsp_pkg::ATAN_Q28[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        z_r[i]   <= z_nxt;
        neg_r[i] <= neg_p;
        sb_r[i]  <= sb_p;
      end
    end
  end

  assign out_vld = vld_r[STEPS-1];
  assign cos_o   = x_r[STEPS-1];
  assign sin_o   = y_r[STEPS-1];
  assign neg_o   = neg_r[STEPS-1];
  assign sb_o    = sb_r[STEPS-1];

endmodule

@@ sv/plsp_chk.sv @@
// Port-level checker of the pose sampler and its bind to the top level.
// Depends on polar_lattice_pose_sampler_top_macros.svh.
`include "polar_lattice_pose_sampler_top_macros.svh"

module plsp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [53:0] out_word,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // hold a waiting result
  `PLSP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `PLSP_ASSERT_HOLD(a_out_stable, clk, rst_n, out_valid && !out_ready, out_word, "result changed")
  // the pipe takes input whenever the output slot frees
  `PLSP_ASSERT(a_in_free, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty output")
  `PLSP_ASSERT(a_in_flow, clk, rst_n, out_ready |-> in_ready, "input blocked while draining")
  `PLSP_ASSERT(a_cfg_ready, clk, rst_n, cfg_valid |-> cfg_ready, "register write refused")

endmodule

bind polar_lattice_pose_sampler_top plsp_chk u_plsp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  ({out_ch.pos_x, out_ch.pos_y, out_ch.yaw}),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);

@@ tb/sv/plsp_tb_if.sv @@
// Testbench copy of the pose sampler channel interfaces is not needed; the RTL
// interfaces in plsp_if are used directly. This file holds shared tb types.
// Depends on plsp_pkg.
package plsp_tb_pkg;

  typedef struct packed {
    logic signed [plsp_pkg::OUT_W-1:0] pos_x;
    logic signed [plsp_pkg::OUT_W-1:0] pos_y;
    logic signed [plsp_pkg::OUT_W-1:0] yaw;
  } pose_t;
endpackage

@@ tb/sv/plsp_pose_checker.sv @@
// Pose checker: watches the register, index and pose channels, predicts each pose.
// Depends on plsp_pkg, plsp_tb_pkg and the plsp_if interfaces.
module plsp_pose_checker (
  input  logic      clk,
  input  logic      rst_n,
  plsp_in_if        in_ch,
  plsp_out_if       out_ch,
  plsp_cfg_if       cfg_ch,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint OUT_HI = 131071;
  localparam longint OUT_LO = -131072;
  localparam int OW = plsp_pkg::OUT_W;

  logic [plsp_pkg::CNT_W-1:0] samples_q, headings_q;
  logic [plsp_pkg::VAL_W-1:0] dist_q, amin_q, amax_q, hmin_q, hmax_q;
  plsp_tb_pkg::pose_t expected_poses[$];

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint sat_out(longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  function automatic plsp_tb_pkg::pose_t predict_pose(logic [plsp_pkg::IDX_W-1:0] ai_in,
                                                      logic [plsp_pkg::IDX_W-1:0] hi_in);
    longint ns, nh, ai, hi, amin, amax, hmin, hmax, a, h, z, x, y, nx, px, py, d;
    bit flip;
    plsp_tb_pkg::pose_t p;
    ns = samples_q > plsp_pkg::DEF_MAX_SAMPLES ? plsp_pkg::DEF_MAX_SAMPLES : samples_q;
    nh = headings_q > plsp_pkg::DEF_MAX_HEADINGS ? plsp_pkg::DEF_MAX_HEADINGS : headings_q;
    ai = longint'(ai_in);
    hi = longint'(hi_in);
    amin = $signed(amin_q);
    amax = $signed(amax_q);
    hmin = $signed(hmin_q);
    hmax = $signed(hmax_q);
    d = longint'(dist_q);
    if (ns <= 1) a = amin;
    else begin
      if (ai > ns - 1) ai = ns - 1;
      a = amin + round_div((amax - amin) * ai, ns - 1);
    end
    if (nh <= 1) h = round_div(hmax - hmin, 2);
    else begin
      if (hi > nh - 1) hi = nh - 1;
      h = hmin + round_div((hmax - hmin) * hi, nh - 1);
    end
    // fold into [-pi/2, pi/2], then rotate
    z = a * 65536;
    flip = 0;
    while (z > plsp_pkg::PI_Q28) z -= plsp_pkg::TWO_PI_Q28;
    while (z < -longint'(plsp_pkg::PI_Q28)) z += plsp_pkg::TWO_PI_Q28;
    if (z > plsp_pkg::HALF_PI_Q28) begin
      z -= plsp_pkg::PI_Q28;
      flip = 1;
    end else if (z < -longint'(plsp_pkg::HALF_PI_Q28)) begin
      z += plsp_pkg::PI_Q28;
      flip = 1;
    end
    x = plsp_pkg::GAIN_Q30;
    y = 0;
    for (int i = 0; i < plsp_pkg::DEF_CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= plsp_pkg::ATAN_Q28[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += plsp_pkg::ATAN_Q28[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = (d * x + (64'sd1 <<< 29)) >>> 30;
    py = (d * y + (64'sd1 <<< 29)) >>> 30;
    p.pos_x = OW'(sat_out(px));
    p.pos_y = OW'(sat_out(py));
    p.yaw = OW'(sat_out(h + a));
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("pose mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = expected_poses.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    plsp_tb_pkg::pose_t want;
    if (!rst_n) begin
      samples_q <= plsp_pkg::RST_SAMPLES;
      headings_q <= plsp_pkg::RST_HEADINGS;
      dist_q <= plsp_pkg::RST_DISTANCE;
      amin_q <= plsp_pkg::RST_AMIN;
      amax_q <= plsp_pkg::RST_AMAX;
      hmin_q <= plsp_pkg::RST_HMIN;
      hmax_q <= plsp_pkg::RST_HMAX;
      expected_poses.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_poses = {expected_poses,
                          predict_pose(in_ch.angle_index, in_ch.heading_index)};
      if (out_ch.valid && out_ch.ready) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected word", out_ch.pos_x, 0);
        end else begin
          want = expected_poses.pop_front();
          if (out_ch.pos_x !== want.pos_x) report_mismatch("pos_x", out_ch.pos_x, want.pos_x);
          if (out_ch.pos_y !== want.pos_y) report_mismatch("pos_y", out_ch.pos_y, want.pos_y);
          if (out_ch.yaw !== want.yaw) report_mismatch("yaw", out_ch.yaw, want.yaw);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          plsp_pkg::REG_SAMPLES:  samples_q <= cfg_ch.data[plsp_pkg::CNT_W-1:0];
          plsp_pkg::REG_HEADINGS: headings_q <= cfg_ch.data[plsp_pkg::CNT_W-1:0];
          plsp_pkg::REG_DISTANCE: dist_q <= cfg_ch.data;
          plsp_pkg::REG_AMIN:     amin_q <= cfg_ch.data;
          plsp_pkg::REG_AMAX:     amax_q <= cfg_ch.data;
          plsp_pkg::REG_HMIN:     hmin_q <= cfg_ch.data;
          plsp_pkg::REG_HMAX:     hmax_q <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Top of the pose sampler regression: clock, reset, stimulus and verdict.
// Depends on plsp_pkg, plsp_if, plsp_pose_checker and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int VW = plsp_pkg::VAL_W;
  localparam int IW = plsp_pkg::IDX_W;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  longint cycle_count;
  bit   calm;   // set for a stretch with no idling on either side

  plsp_in_if  in_ch();
  plsp_out_if out_ch();
  plsp_cfg_if cfg_ch();

  polar_lattice_pose_sampler_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  plsp_pose_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Count cycles; end the run if it hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("polar_lattice_pose_sampler_top regression: fail");
        $finish;
      end
    end
  end

  // Receiver: stall on about 30 percent of cycles, unless in the calm stretch.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // Write one register; hold valid until the word is taken.
  task automatic write_reg(logic [plsp_pkg::CFG_IDX_W-1:0] idx, logic [VW-1:0] value);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  // Send one index word, with a random gap before it unless calm.
  task automatic send_word(logic [IW-1:0] ai, logic [IW-1:0] hi);
    while (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.angle_index <= ai;
    in_ch.heading_index <= hi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for the pipe to empty before touching registers.
  task automatic drain;
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(int ns, int nh, int d, int amin, int amax, int hmin, int hmax);
    write_reg(plsp_pkg::REG_SAMPLES, VW'(ns));
    write_reg(plsp_pkg::REG_HEADINGS, VW'(nh));
    write_reg(plsp_pkg::REG_DISTANCE, VW'(d));
    write_reg(plsp_pkg::REG_AMIN, VW'(amin));
    write_reg(plsp_pkg::REG_AMAX, VW'(amax));
    write_reg(plsp_pkg::REG_HMIN, VW'(hmin));
    write_reg(plsp_pkg::REG_HMAX, VW'(hmax));
  endtask

  // Index mostly in range, sometimes anywhere in the 6-bit field.
  function automatic logic [IW-1:0] pick_index(int n);
    if (n > 1 && $urandom_range(9) < 8) return IW'($urandom_range(n - 1));
    return IW'($urandom);
  endfunction

  initial begin
    int ns, nh;
    rst_n = 0;
    calm = 0;
    in_ch.valid = 0;
    in_ch.angle_index = 0;
    in_ch.heading_index = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = 0;
    cfg_ch.data = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, both index extremes and out-of-range clamping.
    send_word(0, 0);
    send_word(4, 2);
    send_word(2, 1);
    send_word(63, 63);
    drain();

    // Single sample and single heading, counts of zero and one.
    write_all(1, 1, 65535, 12867, -12867, -32768, 32767);
    send_word(0, 0);
    send_word(63, 63);
    drain();
    write_reg(plsp_pkg::REG_SAMPLES, 0);
    write_reg(plsp_pkg::REG_HEADINGS, 0);
    send_word(5, 5);
    drain();

    // Counts above the maximum and full-scale angles.
    write_all(127, 127, 65535, -32768, 32767, 32767, -32768);
    send_word(0, 0);
    send_word(63, 63);
    send_word(31, 42);
    drain();
    write_all(64, 64, 0, 32767, -32768, 0, 0);
    send_word(0, 63);
    send_word(63, 0);
    drain();
    // Unknown register index is ignored.
    write_reg(3'd7, 16'hffff);
    write_all(2, 2, 40000, -6434, 6434, -32768, 32767);
    send_word(0, 0);
    send_word(1, 1);
    send_word(63, 63);
    drain();

    // Random phases; each starts from a fresh random register set.
    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(3))
        0: ns = $urandom_range(127);
        1: ns = $urandom_range(1);
        default: ns = $urandom_range(64, 2);
      endcase
      case ($urandom_range(3))
        0: nh = $urandom_range(127);
        1: nh = $urandom_range(1);
        default: nh = $urandom_range(64, 2);
      endcase
      write_all(ns, nh, $urandom, $urandom, $urandom, $urandom, $urandom);
      calm = (phase == 7);
      for (int k = 0; k < 100; k++) send_word(pick_index(ns), pick_index(nh));
      calm = 0;
      drain();
    end

    if (fail_count == 0) begin
      $display("polar_lattice_pose_sampler_top regression: pass");
    end else begin
      $display("polar_lattice_pose_sampler_top regression: fail");
    end
    $finish;
  end
endmodule
